// ----- hw/rtl/fp8u_pkg.sv -----
// ----------------------------------------------------------------------------
// fp8u_pkg: shared types, constants and functions for the E4M3 unit
// Request and result structs, mode codes, and the E4M3 field helpers.
// ----------------------------------------------------------------------------
package fp8u_pkg;

    typedef enum logic [1:0] {
        MODE_MUL = 2'd0,
        MODE_ADD = 2'd1,
        MODE_CVT = 2'd2,
        MODE_DEC = 2'd3
    } t_mode;

    localparam logic [7:0]  FP8_SIGN    = 8'h80;
    localparam logic [6:0]  FP8_MAXFIN  = 7'h7E;
    localparam logic [6:0]  FP8_NANCODE = 7'h7F;
    localparam logic [31:0] FP32_QNAN   = 32'h7FC0_0000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  operand_a;
        logic [7:0]  operand_b;
        logic [31:0] fp32_in;
    } t_req;

    typedef struct packed {
        logic [7:0]  fp8_out;
        logic [31:0] fp32_out;
    } t_res;

    // magnitude of an E4M3 code in units of 2^-9
    function automatic logic [17:0] fp8_mag(input logic [7:0] v);
        logic [3:0] e;
        logic [17:0] m;
        e = v[6:3];
        m = {14'd0, 1'b1, v[2:0]};
        if (e == 4'd0) begin
            return {15'd0, v[2:0]};
        end
        return m << (e - 4'd1);
    endfunction

    // replace a code that would read as NaN with the largest finite value
    function automatic logic [7:0] avoid_nan(input logic [7:0] c);
        if (c[6:0] == FP8_NANCODE) begin
            return {c[7], FP8_MAXFIN};
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/fp8u_front.sv -----
// ----------------------------------------------------------------------------
// fp8u_front: stage 1 of the E4M3 unit
// Decode operands, form magnitudes and their signed sum.
// ----------------------------------------------------------------------------
module fp8u_front import fp8u_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_req        i_req,
    output logic        o_valid,
    output t_req        o_req,
    output logic [19:0] o_mag,
    output logic        o_sign,
    output logic        o_nan
);
    logic        r_valid;
    t_req        r_req;
    logic [19:0] r_mag;
    logic        r_sign;
    logic        r_nan;

    logic [19:0] n_mag;
    logic        n_sign;
    logic [17:0] ma, mb;
    logic        sa, sb;

    always_comb begin
        ma = fp8_mag(i_req.operand_a);
        mb = fp8_mag(i_req.operand_b);
        sa = i_req.operand_a[7];
        sb = i_req.operand_b[7];
        n_mag  = '0;
        n_sign = 1'b0;
        if (i_req.mode == MODE_DEC) begin
            n_mag  = {2'd0, ma};
            n_sign = sa;
        end else if (sa == sb) begin
            n_mag  = {2'd0, ma} + {2'd0, mb};
            n_sign = sa;
        end else if (ma > mb) begin
            n_mag  = {2'd0, ma - mb};
            n_sign = sa;
        end else if (mb > ma) begin
            n_mag  = {2'd0, mb - ma};
            n_sign = sb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_req  <= i_req;
        r_mag  <= n_mag;
        r_sign <= n_sign;
        r_nan  <= (i_req.operand_a[6:0] == FP8_NANCODE)
               || (i_req.mode == MODE_ADD && i_req.operand_b[6:0] == FP8_NANCODE);
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;
    assign o_mag   = r_mag;
    assign o_sign  = r_sign;
    assign o_nan   = r_nan;
endmodule

// ----- hw/rtl/fp8u_norm.sv -----
// ----------------------------------------------------------------------------
// fp8u_norm: stage 2 of the E4M3 unit
// Normalize the magnitude to fp32 bits, form the multiply product.
// ----------------------------------------------------------------------------
module fp8u_norm import fp8u_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_req        i_req,
    input  logic [19:0] i_mag,
    input  logic        i_sign,
    input  logic        i_nan,
    output logic        o_valid,
    output t_req        o_req,
    output logic [31:0] o_bits,
    output logic        o_nan,
    output logic [7:0]  o_mul
);
    logic        r_valid;
    t_req        r_req;
    logic [31:0] r_bits;
    logic        r_nan;
    logic [7:0]  r_mul;

    logic [31:0] n_bits;
    logic [7:0]  n_mul;
    logic [4:0]  p;
    logic [42:0] sh;
    logic [7:0]  prod, pm;
    logic [5:0]  e;
    logic [4:0]  mant;

    always_comb begin
        // leading one position
        p = 5'd0;
        for (int k = 0; k < 20; k++) begin
            if (i_mag[k]) begin
                p = 5'(k);
            end
        end
        sh = {23'd0, i_mag} << (5'd23 - p);
        if (i_mag == 20'd0) begin
            n_bits = {i_sign, 31'd0};
        end else begin
            n_bits = {i_sign, 8'(p) + 8'd118, sh[22:0]};
        end

        prod = {4'd0, 1'b1, i_req.operand_a[2:0]} * {4'd0, 1'b1, i_req.operand_b[2:0]};
        e = {2'd0, i_req.operand_a[6:3]} + {2'd0, i_req.operand_b[6:3]} + {5'd0, prod[7]};
        pm = prod[7] ? {1'b0, prod[7:1]} : prod;
        mant = 5'((pm + 8'd4) >> 3);
        e = e + {5'd0, mant[4]};
        // e holds biased sum + 7; valid range after saturation is 7..22
        if (e < 6'd7) begin
            n_mul = {i_req.operand_a[7] ^ i_req.operand_b[7], 4'd0, mant[2:0]};
        end else if (e > 6'd22) begin
            n_mul = {i_req.operand_a[7] ^ i_req.operand_b[7], 4'hF, mant[2:0]};
        end else begin
            n_mul = {i_req.operand_a[7] ^ i_req.operand_b[7], 4'(e - 6'd7), mant[2:0]};
        end
        n_mul = avoid_nan(n_mul);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_req  <= i_req;
        r_bits <= n_bits;
        r_nan  <= i_nan;
        r_mul  <= n_mul;
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;
    assign o_bits  = r_bits;
    assign o_nan   = r_nan;
    assign o_mul   = r_mul;
endmodule

// ----- hw/rtl/fp8u_round.sv -----
// ----------------------------------------------------------------------------
// fp8u_round: stage 3 of the E4M3 unit
// Round fp32 bits to E4M3 and select the result per mode.
// ----------------------------------------------------------------------------
module fp8u_round import fp8u_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_req        i_req,
    input  logic [31:0] i_bits,
    input  logic        i_nan,
    input  logic [7:0]  i_mul,
    output logic        o_valid,
    output t_res        o_res
);
    logic r_valid;
    t_res r_res;
    t_res n_res;

    logic [31:0] x;
    logic        s;
    logic [7:0]  ef;
    logic [22:0] mt;
    logic [23:0] full;
    logic [1:0]  shs;
    logic [3:0]  m8;
    logic        rb, st, g;
    logic [3:0]  m3;
    logic [4:0]  e8;
    logic [7:0]  cvt;
    logic [23:0] lowmask;

    always_comb begin
        x    = (i_req.mode == MODE_CVT) ? i_req.fp32_in : i_bits;
        s    = x[31];
        ef   = x[30:23];
        mt   = x[22:0];
        full = {1'b1, mt};
        shs  = 2'd0;
        m8   = '0;
        rb   = 1'b0;
        st   = 1'b0;
        g    = 1'b0;
        m3   = '0;
        e8   = '0;
        lowmask = '0;
        if (ef == 8'hFF && mt != 23'd0) begin
            cvt = {1'b0, FP8_NANCODE};
        end else if (ef > 8'd135) begin
            cvt = {s, FP8_MAXFIN};
        end else if (ef < 8'd118) begin
            cvt = {s, 7'd0};
        end else if (ef < 8'd121) begin
            shs = 2'(8'd121 - ef);  // 1..3
            m8  = 4'(full >> (5'd20 + {3'd0, shs}));
            rb  = full[5'd19 + {3'd0, shs}];
            lowmask = (24'd1 << (5'd19 + {3'd0, shs})) - 24'd1;
            st  = (full & lowmask) != 24'd0;
            m8  = m8 + {3'd0, rb & (m8[0] | st)};
            if (m8 > 4'd7) begin
                m8 = 4'd7;
            end
            cvt = {s, 4'd0, m8[2:0]};
        end else begin
            e8 = 5'(ef - 8'd120);
            m3 = {1'b0, mt[22:20]};
            g  = mt[19];
            st = mt[18:0] != 19'd0;
            m3 = m3 + {3'd0, g & (m3[0] | st)};
            if (m3 > 4'd7) begin
                m3 = 4'd0;
                e8 = e8 + 5'd1;
            end
            if (e8 > 5'd15) begin
                cvt = {s, FP8_MAXFIN};
            end else begin
                cvt = avoid_nan({s, e8[3:0], m3[2:0]});
            end
        end

        n_res = '0;
        unique case (i_req.mode)
            MODE_MUL: n_res.fp8_out = i_mul;
            MODE_ADD: n_res.fp8_out = i_nan ? {1'b0, FP8_NANCODE} : cvt;
            MODE_CVT: n_res.fp8_out = cvt;
            MODE_DEC: n_res.fp32_out = i_nan ? FP32_QNAN : i_bits;
            default:  n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

// ----- hw/rtl/fp8_e4m3_arith_unit_core.sv -----
// ----------------------------------------------------------------------------
// fp8_e4m3_arith_unit_core: E4M3 FP8 arithmetic unit
// Each accepted request passes the front, norm and round registers to o_done.
// Throughput: one request per cycle; busy is always low.
// Reset: synchronous active-low i_rst_n clears the stage valid bits.
// The receiver cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module fp8_e4m3_arith_unit_core import fp8u_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_res o_res
);
    logic        v1, v2;
    t_req        q1, q2;
    logic [19:0] mag1;
    logic        sign1, nan1, nan2;
    logic [31:0] bits2;
    logic [7:0]  mul2;

    // stateless pipeline: never hold off requests
    assign busy = 1'b0;

    // stage 1: magnitudes and signed sum
    fp8u_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start & ~busy), .i_req(i_req),
        .o_valid(v1), .o_req(q1), .o_mag(mag1), .o_sign(sign1), .o_nan(nan1)
    );

    // stage 2: normalize to fp32, multiply
    fp8u_norm u_norm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v1), .i_req(q1), .i_mag(mag1),
        .i_sign(sign1), .i_nan(nan1),
        .o_valid(v2), .o_req(q2), .o_bits(bits2), .o_nan(nan2), .o_mul(mul2)
    );

    // stage 3: round and select by mode
    fp8u_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v2), .i_req(q2), .i_bits(bits2),
        .i_nan(nan2), .i_mul(mul2), .o_valid(o_done), .o_res(o_res)
    );
endmodule

// ----- tb/sv/fp8_e4m3_arith_unit_core_tb.sv -----
// ----------------------------------------------------------------------------
// fp8_e4m3_arith_unit_core_tb: self-checking bench for the E4M3 unit
// Streams directed and random requests through all four modes, predicts each
// result with a local E4M3 model and compares every o_done strobe in order.
// ----------------------------------------------------------------------------
module fp8_e4m3_arith_unit_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fp8u_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_done;
    t_res o_res;

    t_req pending_reqs[$];
    t_res expected_res[$];
    int   error_count;
    int   idle_pct;
    int   mode_seen[4];
    bit   stim_done;

    fp8_e4m3_arith_unit_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_done (o_done),
        .o_res  (o_res)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // E4M3 prediction
    // ------------------------------------------------------------------

    // magnitude of a code in units of 2^-9
    function automatic logic [19:0] code_magnitude(input logic [7:0] v);
        logic [3:0] e;
        e = v[6:3];
        if (e == 4'd0) return {17'd0, v[2:0]};
        return {16'd0, 1'b1, v[2:0]} << (e - 4'd1);
    endfunction

    // exact single-precision bits of sign * mag * 2^-9
    function automatic logic [31:0] scaled_single(input logic s, input logic [19:0] mag);
        int p;
        logic [31:0] frac;
        if (mag == 20'd0) return {s, 31'd0};
        p = 19;
        while (mag[p] == 1'b0) p--;
        frac = 32'(mag) << (23 - p);
        return {s, 8'(p + 118), frac[22:0]};
    endfunction

    function automatic logic [7:0] clamp_nan(input logic [7:0] c);
        if (c[6:0] == FP8_NANCODE) return {c[7], FP8_MAXFIN};
        return c;
    endfunction

    function automatic logic [7:0] single_to_code(input logic [31:0] bits);
        logic s;
        logic [22:0] mant;
        logic [23:0] full;
        int ex, sh;
        logic [4:0] e8;
        logic [3:0] m;
        logic rb, st;
        s = bits[31];
        mant = bits[22:0];
        ex = int'(bits[30:23]) - 127;
        if (bits[30:23] == 8'hFF && mant != 0) return {1'b0, FP8_NANCODE};
        if (ex > 8) return {s, FP8_MAXFIN};
        if (ex < -9) return {s, 7'd0};
        if (ex < -6) begin
            sh = -6 - ex;
            full = {1'b1, mant};
            m = 4'(full >> (20 + sh));
            rb = full[19 + sh];
            st = (full & ((24'd1 << (19 + sh)) - 24'd1)) != 0;
            m = m + 4'(rb & (m[0] | st));
            if (m > 4'd7) m = 4'd7;
            return {s, 4'd0, m[2:0]};
        end
        e8 = 5'(ex + 7);
        m = {1'b0, mant[22:20]};
        rb = mant[19];
        st = mant[18:0] != 0;
        m = m + 4'(rb & (m[0] | st));
        if (m > 4'd7) begin
            m = 4'd0;
            e8++;
            if (e8 > 5'd15) return {s, FP8_MAXFIN};
        end
        return clamp_nan({s, e8[3:0], m[2:0]});
    endfunction

    function automatic logic [7:0] approx_product(input logic [7:0] a, input logic [7:0] b);
        int e, sh;
        int unsigned m, mant;
        e = int'(a[6:3]) + int'(b[6:3]) - 7;
        m = {28'd1, a[2:0]} * {28'd1, b[2:0]};
        sh = m >> 7;
        m = m >> sh;
        e += sh;
        mant = (m + 4) >> 3;
        e += mant >> 4;
        if (e < 0) e = 0;
        if (e > 15) e = 15;
        return clamp_nan({a[7] ^ b[7], 4'(e), 3'(mant)});
    endfunction

    function automatic logic [7:0] exact_sum(input logic [7:0] a, input logic [7:0] b);
        logic [19:0] ma, mb, mag;
        logic s;
        if (a[6:0] == FP8_NANCODE || b[6:0] == FP8_NANCODE) return {1'b0, FP8_NANCODE};
        ma = code_magnitude(a);
        mb = code_magnitude(b);
        if (a[7] == b[7]) begin
            mag = ma + mb; s = a[7];
        end else if (ma > mb) begin
            mag = ma - mb; s = a[7];
        end else if (mb > ma) begin
            mag = mb - ma; s = b[7];
        end else begin
            mag = 0; s = 1'b0;
        end
        return single_to_code(scaled_single(s, mag));
    endfunction

    function automatic t_res predict_result(input t_req r);
        t_res x;
        x = '0;
        case (t_mode'(r.mode))
            MODE_MUL: x.fp8_out = approx_product(r.operand_a, r.operand_b);
            MODE_ADD: x.fp8_out = exact_sum(r.operand_a, r.operand_b);
            MODE_CVT: x.fp8_out = single_to_code(r.fp32_in);
            default: begin
                if (r.operand_a[6:0] == FP8_NANCODE) x.fp32_out = FP32_QNAN;
                else x.fp32_out = scaled_single(r.operand_a[7], code_magnitude(r.operand_a));
            end
        endcase
        return x;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    task automatic push_req(input t_mode m, input logic [7:0] a, input logic [7:0] b,
                            input logic [31:0] f);
        t_req r;
        r.mode = m;
        r.operand_a = a;
        r.operand_b = b;
        r.fp32_in = f;
        pending_reqs.push_back(r);
    endtask

    // single-precision pattern biased toward the E4M3 range
    function automatic logic [31:0] rand_single();
        logic [31:0] f;
        f = $urandom;
        case ($urandom_range(0, 9))
            0, 1: ;
            2: f[30:23] = 8'hFF;
            3: f[30:23] = 8'(127 + $urandom_range(0, 1) * 2 - 1 + 8);
            4: f[30:23] = 8'($urandom_range(0, 1) ? 0 : $urandom_range(115, 118));
            5: begin
                f[30:23] = 8'($urandom_range(118, 135));
                f[19:0] = $urandom_range(0, 1) ? 20'h80000 : 20'h0;
            end
            default: f[30:23] = 8'($urandom_range(116, 137));
        endcase
        return f;
    endfunction

    initial begin
        // directed: field extremes, each mode, NaN, zeros, saturation, carries
        push_req(MODE_MUL, 8'h00, 8'h00, 32'h0);
        push_req(MODE_MUL, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        push_req(MODE_MUL, 8'h7E, 8'h7E, 32'h0);
        push_req(MODE_MUL, 8'h3F, 8'h47, 32'h0);
        push_req(MODE_MUL, 8'hB8, 8'h08, 32'h0);
        push_req(MODE_ADD, 8'h7F, 8'h01, 32'h0);
        push_req(MODE_ADD, 8'h00, 8'hFF, 32'h0);
        push_req(MODE_ADD, 8'h80, 8'h80, 32'h0);
        push_req(MODE_ADD, 8'h45, 8'hC5, 32'h0);
        push_req(MODE_ADD, 8'h7E, 8'h7E, 32'h0);
        push_req(MODE_ADD, 8'h01, 8'h01, 32'h0);
        push_req(MODE_ADD, 8'hFE, 8'h7D, 32'h0);
        push_req(MODE_CVT, 8'h00, 8'h00, 32'h7FC0_0000);
        push_req(MODE_CVT, 8'h00, 8'h00, 32'hFF80_0000);
        push_req(MODE_CVT, 8'h00, 8'h00, 32'h8000_0001);
        push_req(MODE_CVT, 8'h00, 8'h00, 32'h3B00_0000);
        push_req(MODE_CVT, 8'h00, 8'h00, 32'h3AFF_FFFF);
        push_req(MODE_CVT, 8'h00, 8'h00, 32'h3BF0_0000);
        push_req(MODE_CVT, 8'h00, 8'h00, 32'h43F0_0000);
        push_req(MODE_CVT, 8'h00, 8'h00, 32'hC3E8_0000);
        push_req(MODE_CVT, 8'h00, 8'h00, 32'h3F88_0000);
        push_req(MODE_DEC, 8'h7F, 8'h00, 32'h0);
        push_req(MODE_DEC, 8'hFF, 8'hFF, 32'h0);
        push_req(MODE_DEC, 8'h80, 8'h00, 32'h0);
        push_req(MODE_DEC, 8'h01, 8'h00, 32'h0);
        for (int i = 0; i < 1400; i++) begin
            push_req(t_mode'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), rand_single());
        end
    end

    // ------------------------------------------------------------------
    // Driver: pop a request when the sender is not idling this cycle
    // ------------------------------------------------------------------
    int sent;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            // retire the request accepted at this edge
            if (start && !busy) begin
                expected_res.push_back(predict_result(i_req));
                mode_seen[i_req.mode]++;
                sent++;
            end
            if (!(start && busy)) begin
                // advance the idle phase every 350 requests
                idle_pct = ((sent / 350) % 4 == 1) ? 48 : ((sent / 350) % 4 == 3) ? 8 : 0;
                if (pending_reqs.size() > 0 && $urandom_range(1, 100) > idle_pct) begin
                    start <= 1'b1;
                    i_req <= pending_reqs.pop_front();
                end else begin
                    start <= 1'b0;
                    i_req <= t_req'({$urandom, $urandom});
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each strobed result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_done) begin
            if (expected_res.size() == 0) begin
                $error("unexpected result fp8_out=%h fp32_out=%h", o_res.fp8_out, o_res.fp32_out);
                error_count++;
            end else begin
                want = expected_res.pop_front();
                if (o_res.fp8_out !== want.fp8_out) begin
                    $error("fp8_out expected %h actual %h", want.fp8_out, o_res.fp8_out);
                    error_count++;
                end
                if (o_res.fp32_out !== want.fp32_out) begin
                    $error("fp32_out expected %h actual %h", want.fp32_out, o_res.fp32_out);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Reset, drain and verdict
    // ------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        sent = 0;
        error_count = 0;
        idle_pct = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // hold until every request is accepted and every result is back
        @(posedge i_clk);
        wait (pending_reqs.size() == 0 && start == 1'b0);
        wait (expected_res.size() == 0);
        repeat (10) @(posedge i_clk);
        if (expected_res.size() != 0) error_count++;
        $display("covered %0d requests: mul %0d, add %0d, cvt %0d, dec %0d",
                 sent, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
        $display("idle phases 0, 48 and 8 percent on the request side");
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #1ms;
        $display("status: fail");
        $finish;
    end

endmodule
